@@ hdl/mrw_pkg.sv @@
// Shared constants for the Miller-Rabin witness test core.
// No dependencies.
`timescale 1ns / 1ps
package mrw_pkg;
    localparam int FIELD_W      = 63;   // width of modulus_n and witness_base
    localparam int S_TDATA_W    = 128;  // two fields packed, padded to bytes
    localparam int M_TDATA_W    = 8;    // is_composite, padded to a byte
    localparam int NUM_BITS_DEF = 63;
endpackage

@@ hdl/mrw_mulmod.sv @@
// Bit-serial modular multiplier: (a * b) mod n, one bit of b per cycle.
// Depends on nothing; operand width follows NUM_BITS.
`timescale 1ns / 1ps
module mrw_mulmod #(
    parameter int NUM_BITS = 63
) (
    input  logic                aclk,
    input  logic                aresetn,
    input  logic                start,
    input  logic [NUM_BITS-1:0] op_a,
    input  logic [NUM_BITS-1:0] op_b,
    input  logic [NUM_BITS-1:0] modulus,
    output logic                done,
    output logic [NUM_BITS-1:0] result
);
    localparam int CNT_W = $clog2(NUM_BITS + 1);

    logic                busy_reg, busy_next;
    logic                done_reg, done_next;
    logic [CNT_W-1:0]    cnt_reg, cnt_next;
    logic [NUM_BITS-1:0] acc_reg, acc_next;
    logic [NUM_BITS-1:0] a_reg, a_next;
    logic [NUM_BITS-1:0] b_reg, b_next;
    logic [NUM_BITS-1:0] n_reg, n_next;
    logic [NUM_BITS:0]   dbl, red1, sum, red2, n_ext;

    always_comb begin
        n_ext = {1'b0, n_reg};
        dbl   = {acc_reg, 1'b0};
        red1  = (dbl >= n_ext) ? dbl - n_ext : dbl;
        sum   = red1 + {1'b0, a_reg};
        red2  = (sum >= n_ext) ? sum - n_ext : sum;

        busy_next = busy_reg;
        done_next = 1'b0;
        cnt_next  = cnt_reg;
        acc_next  = acc_reg;
        a_next    = a_reg;
        b_next    = b_reg;
        n_next    = n_reg;
        if (start) begin
            busy_next = 1'b1;
            cnt_next  = CNT_W'(NUM_BITS);
            acc_next  = '0;
            a_next    = op_a;
            b_next    = op_b;
            n_next    = modulus;
        end else if (busy_reg) begin
            acc_next = b_reg[NUM_BITS-1] ? red2[NUM_BITS-1:0] : red1[NUM_BITS-1:0];
            b_next   = {b_reg[NUM_BITS-2:0], 1'b0};
            cnt_next = cnt_reg - 1'b1;
            if (cnt_reg == CNT_W'(1)) begin
                busy_next = 1'b0;
                done_next = 1'b1;
            end
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            busy_reg <= 1'b0;
            done_reg <= 1'b0;
            cnt_reg  <= '0;
        end else begin
            busy_reg <= busy_next;
            done_reg <= done_next;
            cnt_reg  <= cnt_next;
        end
        acc_reg <= acc_next;
        a_reg   <= a_next;
        b_reg   <= b_next;
        n_reg   <= n_next;
    end

    assign done   = done_reg;
    assign result = acc_reg;
endmodule

@@ hdl/miller_rabin_witness_test_core.sv @@
// Miller-Rabin witness test top level: sequencer around one shared mulmod unit.
// Depends on mrw_pkg and mrw_mulmod.
`timescale 1ns / 1ps
// One item (modulus n, witness base) gives one item (is_composite). n = 2 is
// prime, n = 1 and even n are composite; both are decided in the idle state.
// Odd n first strips the tz trailing zeros of n-1, then reduces the base mod n,
// raises it to (n-1) >> tz by square and multiply, and squares the result up to
// tz times, stopping early on a nontrivial square root of 1.
// Every modular product runs through the single bit-serial multiplier, one
// bit per cycle, and one item is worked on at a time. s_tready is high only
// between items.
module miller_rabin_witness_test_core #(
    parameter int NUM_BITS = mrw_pkg::NUM_BITS_DEF
) (
    input  logic                           aclk,
    input  logic                           aresetn,
    input  logic                           s_tvalid,
    output logic                           s_tready,
    // [62:0] modulus_n, [125:63] witness_base, [127:126] zero
    input  logic [mrw_pkg::S_TDATA_W-1:0]  s_tdata,
    output logic                           m_tvalid,
    input  logic                           m_tready,
    // [0] is_composite, [7:1] zero
    output logic [mrw_pkg::M_TDATA_W-1:0]  m_tdata
);
    import mrw_pkg::*;

    localparam int J_W = $clog2(NUM_BITS + 1);

    typedef enum logic [3:0] {
        ST_IDLE, ST_SHIFT, ST_REDUCE, ST_POW, ST_MUL_R, ST_MUL_B,
        ST_SQR_CHK, ST_SQR, ST_DONE
    } state_t;

    state_t              state_reg, state_next;
    logic [NUM_BITS-1:0] n_reg, n_next;
    logic [NUM_BITS-1:0] base_reg, base_next;
    logic [NUM_BITS-1:0] e_reg, e_next;
    logic [NUM_BITS-1:0] r_reg, r_next;
    logic [NUM_BITS-1:0] x_reg, x_next;
    logic [J_W-1:0]      j_reg, j_next;
    logic                res_reg, res_next;
    logic                mv_reg, mv_next;
    logic                md_reg, md_next;
    logic                start_reg, start_next;
    logic [NUM_BITS-1:0] op_a_reg, op_a_next;
    logic [NUM_BITS-1:0] op_b_reg, op_b_next;

    logic                mm_done;
    logic [NUM_BITS-1:0] mm_res;
    logic [NUM_BITS-1:0] in_n, in_base, one, n_m1;

    mrw_mulmod #(.NUM_BITS(NUM_BITS)) u_mulmod (
        .aclk    (aclk),
        .aresetn (aresetn),
        .start   (start_reg),
        .op_a    (op_a_reg),
        .op_b    (op_b_reg),
        .modulus (n_reg),
        .done    (mm_done),
        .result  (mm_res)
    );

    assign in_n    = s_tdata[NUM_BITS-1:0];
    assign in_base = s_tdata[FIELD_W+NUM_BITS-1:FIELD_W];
    assign one     = NUM_BITS'(1);
    assign n_m1    = n_reg - one;
    assign s_tready = (state_reg == ST_IDLE);

    always_comb begin
        state_next = state_reg;
        n_next     = n_reg;
        base_next  = base_reg;
        e_next     = e_reg;
        r_next     = r_reg;
        x_next     = x_reg;
        j_next     = j_reg;
        res_next   = res_reg;
        start_next = 1'b0;
        op_a_next  = op_a_reg;
        op_b_next  = op_b_reg;
        mv_next    = mv_reg && !m_tready;
        md_next    = md_reg;

        case (state_reg)
            ST_IDLE: begin
                if (s_tvalid) begin
                    n_next    = in_n;
                    base_next = in_base;
                    if (in_n == NUM_BITS'(2)) begin
                        res_next   = 1'b0;
                        state_next = ST_DONE;
                    end else if (in_n == one || !in_n[0]) begin
                        res_next   = 1'b1;
                        state_next = ST_DONE;
                    end else begin
                        e_next     = in_n - one;
                        j_next     = '0;
                        state_next = ST_SHIFT;
                    end
                end
            end
            ST_SHIFT: begin
                if (!e_reg[0]) begin
                    e_next = e_reg >> 1;
                    j_next = j_reg + 1'b1;
                end else begin
                    // base mod n as 1 * base mod n
                    start_next = 1'b1;
                    op_a_next  = one;
                    op_b_next  = base_reg;
                    state_next = ST_REDUCE;
                end
            end
            ST_REDUCE: begin
                if (mm_done) begin
                    base_next  = mm_res;
                    r_next     = one;
                    state_next = ST_POW;
                end
            end
            ST_POW: begin
                if (e_reg == '0) begin
                    x_next     = r_reg;
                    state_next = ST_SQR_CHK;
                end else if (e_reg[0]) begin
                    start_next = 1'b1;
                    op_a_next  = r_reg;
                    op_b_next  = base_reg;
                    state_next = ST_MUL_R;
                end else begin
                    start_next = 1'b1;
                    op_a_next  = base_reg;
                    op_b_next  = base_reg;
                    state_next = ST_MUL_B;
                end
            end
            ST_MUL_R: begin
                if (mm_done) begin
                    r_next     = mm_res;
                    start_next = 1'b1;
                    op_a_next  = base_reg;
                    op_b_next  = base_reg;
                    state_next = ST_MUL_B;
                end
            end
            ST_MUL_B: begin
                if (mm_done) begin
                    base_next  = mm_res;
                    e_next     = e_reg >> 1;
                    state_next = ST_POW;
                end
            end
            ST_SQR_CHK: begin
                // j >= 1 for odd n, so x here is the last square when j hits 0
                if (j_reg == '0) begin
                    res_next   = (x_reg != one);
                    state_next = ST_DONE;
                end else begin
                    start_next = 1'b1;
                    op_a_next  = x_reg;
                    op_b_next  = x_reg;
                    state_next = ST_SQR;
                end
            end
            ST_SQR: begin
                if (mm_done) begin
                    if (mm_res == one && x_reg != one && x_reg != n_m1) begin
                        // nontrivial square root of 1
                        res_next   = 1'b1;
                        state_next = ST_DONE;
                    end else begin
                        x_next     = mm_res;
                        j_next     = j_reg - 1'b1;
                        state_next = ST_SQR_CHK;
                    end
                end
            end
            ST_DONE: begin
                if (!mv_reg || m_tready) begin
                    mv_next    = 1'b1;
                    md_next    = res_reg;
                    state_next = ST_IDLE;
                end
            end
            default: state_next = ST_IDLE;
        endcase
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg <= ST_IDLE;
            mv_reg    <= 1'b0;
            start_reg <= 1'b0;
        end else begin
            state_reg <= state_next;
            mv_reg    <= mv_next;
            start_reg <= start_next;
        end
        n_reg    <= n_next;
        base_reg <= base_next;
        e_reg    <= e_next;
        r_reg    <= r_next;
        x_reg    <= x_next;
        j_reg    <= j_next;
        res_reg  <= res_next;
        md_reg   <= md_next;
        op_a_reg <= op_a_next;
        op_b_reg <= op_b_next;
    end

    assign m_tvalid = mv_reg;
    assign m_tdata  = {{(M_TDATA_W-1){1'b0}}, md_reg};
endmodule
